// File: hdl/bc_pkg.sv
// Shared types and constants for the barometric compensation block.
package bc_pkg;

    typedef enum logic [7:0] {
        REG_CAL_A = 8'd0,
        REG_CAL_B = 8'd1,
        REG_CAL_C = 8'd2,
        REG_OSS   = 8'd3
    } reg_index_t;

    localparam logic [31:0] B6_OFS   = 32'd4000;
    localparam logic [31:0] B4_OFS   = 32'd32768;
    localparam logic [31:0] B7_NUM   = 32'd50000;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] P_K1     = 32'd3038;
    localparam logic [31:0] P_K2     = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] P_K3     = 32'd3791;
    localparam logic [1:0]  OSS_RST  = 2'd3;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } cal_t;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [18:0] raw_press;
    } item_t;

    // queue head toward the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

// File: hdl/bc_if.sv
// Channel interfaces: sample in, result out, configuration writes.
interface bc_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temp;
    logic [18:0] raw_press;
    modport source (output valid, raw_temp, raw_press, input ready);
    modport sink   (input valid, raw_temp, raw_press, output ready);
endinterface

interface bc_result_if;
    logic               valid;
    logic               ready;
    logic signed [27:0] temp_tenths;
    logic signed [31:0] pressure_pa;
    logic               div_error;
    modport source (output valid, temp_tenths, pressure_pa, div_error, input ready);
    modport sink   (input valid, temp_tenths, pressure_pa, div_error, output ready);
endinterface

interface bc_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  reg_index;
    logic [63:0] wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: hdl/bc_front.sv
// Front end: accepts sample requests into a two-entry queue.
module bc_front (
    input  logic          clk,
    input  logic          rst_n,
    bc_sample_if.sink     sample,
    input  logic          pop,
    output bc_pkg::q_head_t head
);
    import bc_pkg::*;

    item_t       mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push, do_pop;

    assign sample.ready = (count_reg != 2'd2);
    assign push   = sample.valid && sample.ready;
    assign do_pop = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{raw_temp: sample.raw_temp, raw_press: sample.raw_press};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (!push && do_pop)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// File: hdl/bc_div.sv
// Iterative unsigned 32/32 divider, one quotient bit per cycle.
module bc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    localparam int W = 32;
    localparam int CW = $clog2(W + 1);

    logic [W:0]    rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [W:0]    rem_sh;
    logic          fits;

    assign rem_sh   = {rem_reg[W-1:0], quo_reg[W-1]};
    assign fits     = (rem_sh >= {1'b0, den_reg});
    assign quotient = quo_reg;
    assign done     = busy_reg && (cnt_reg == CW'(W));

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg && !done)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

endmodule

// File: hdl/bc_core.sv
// Back end: sequencer with a shared multiplier and divider, plus the result register.
module bc_core (
    input  logic           clk,
    input  logic           rst_n,
    input  bc_pkg::cal_t   cal,
    input  bc_pkg::q_head_t head,
    output logic           pop,
    bc_result_if.source    result
);
    import bc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_T1, S_T2, S_TDIV, S_T3,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_PDIV,
        S_M9, S_M10, S_M11, S_M12, S_DONE
    } state_t;

    state_t      state_reg;
    logic [15:0] ut_reg;
    logic [18:0] up_reg;
    logic [31:0] x1_reg, x2_reg, b5_reg, b6_reg, sq_reg, b3_reg, b4_reg, b7_reg, p_reg;
    logic        neg_reg, hi_reg, err_reg;

    logic               out_valid_reg;
    logic signed [27:0] out_temp_reg;
    logic signed [31:0] out_press_reg;
    logic               out_err_reg;

    logic [31:0] mul_a, mul_b, prod;
    logic        div_start, div_done;
    logic [31:0] div_n, div_d, div_q;
    logic [31:0] tdiv, tnum, b3v, x3v, ps, b5p8, q_signed, rnd;
    logic        out_free, out_load;

    assign pop      = (state_reg == S_IDLE) && head.valid;
    assign out_free = !out_valid_reg || result.ready;
    assign out_load = (state_reg == S_DONE) && out_free;

    assign tdiv     = x1_reg + sx16(cal.md);
    assign tnum     = sx16(cal.mc) << 11;
    // ((ac1*4 + x3) << oss) + 2, then /4 truncating toward zero
    assign b3v      = (((sx16(cal.ac1) << 2) + x1_reg + x2_reg) << cal.oss) + 32'd2;
    assign x3v      = $unsigned($signed(x1_reg + x2_reg + 32'd2) >>> 2);
    assign ps       = $unsigned($signed(p_reg) >>> 8);
    assign b5p8     = b5_reg + 32'd8;
    assign q_signed = neg_reg ? (32'd0 - div_q) : div_q;
    assign rnd      = $unsigned($signed(x1_reg + x2_reg + P_K3) >>> 4);
    assign prod     = mul_a * mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_T1:
            begin
                mul_a = {16'd0, ut_reg} - {16'd0, cal.ac6};
                mul_b = {16'd0, cal.ac5};
            end
            S_M1:  begin mul_a = b6_reg;            mul_b = b6_reg;                    end
            S_M2:  begin mul_a = sx16(cal.b2);      mul_b = sq_reg;                    end
            S_M3:  begin mul_a = sx16(cal.ac2);     mul_b = b6_reg;                    end
            S_M4:  begin mul_a = sx16(cal.ac3);     mul_b = b6_reg;                    end
            S_M5:  begin mul_a = sx16(cal.b1);      mul_b = sq_reg;                    end
            S_M6:  begin mul_a = {16'd0, cal.ac4};  mul_b = x3v + B4_OFS;              end
            S_M7:  begin mul_a = {13'd0, up_reg} - b3_reg; mul_b = B7_NUM >> cal.oss;  end
            S_M9:  begin mul_a = ps;                mul_b = ps;                        end
            S_M10: begin mul_a = x1_reg;            mul_b = P_K1;                      end
            S_M11: begin mul_a = P_K2;              mul_b = p_reg;                     end
            default: ;
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        unique case (state_reg)
            S_T2:
            begin
                div_start = (tdiv != 32'd0);
                div_n     = tnum[31] ? (32'd0 - tnum) : tnum;
                div_d     = tdiv[31] ? (32'd0 - tdiv) : tdiv;
            end
            S_M8:
            begin
                // unsigned branch: small B7 is doubled before the divide
                div_start = 1'b1;
                div_n     = b7_reg[31] ? b7_reg : (b7_reg << 1);
                div_d     = b4_reg;
            end
            default: ;
        endcase
    end

    bc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign result.valid       = out_valid_reg;
    assign result.temp_tenths = out_temp_reg;
    assign result.pressure_pa = out_press_reg;
    assign result.div_error   = out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_temp_reg  <= '0;
            out_press_reg <= '0;
            out_err_reg   <= 1'b0;
            ut_reg  <= '0;  up_reg  <= '0;
            x1_reg  <= '0;  x2_reg  <= '0;  b5_reg <= '0;
            b6_reg  <= '0;  sq_reg  <= '0;  b3_reg <= '0;
            b4_reg  <= '0;  b7_reg  <= '0;  p_reg  <= '0;
            neg_reg <= 1'b0; hi_reg <= 1'b0; err_reg <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        ut_reg    <= head.item.raw_temp;
                        up_reg    <= head.item.raw_press;
                        err_reg   <= 1'b0;
                        state_reg <= S_T1;
                    end
                end
                S_T1:
                begin
                    x1_reg    <= $unsigned($signed(prod) >>> 15);
                    state_reg <= S_T2;
                end
                S_T2:
                begin
                    neg_reg <= tnum[31] ^ tdiv[31];
                    if (tdiv == 32'd0)
                    begin
                        err_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_TDIV;
                end
                S_TDIV:
                begin
                    if (div_done)
                    begin
                        b5_reg    <= x1_reg + q_signed;
                        state_reg <= S_T3;
                    end
                end
                S_T3:
                begin
                    b6_reg    <= b5_reg - B6_OFS;
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    sq_reg    <= $unsigned($signed(prod) >>> 12);
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    x1_reg    <= $unsigned($signed(prod) >>> 11);
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    x2_reg    <= $unsigned($signed(prod) >>> 11);
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    b3_reg    <= b3v[31] ? $unsigned($signed(b3v + 32'd3) >>> 2)
                                         : (b3v >> 2);
                    x1_reg    <= $unsigned($signed(prod) >>> 13);
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    x2_reg    <= $unsigned($signed(prod) >>> 16);
                    state_reg <= S_M6;
                end
                S_M6:
                begin
                    b4_reg    <= prod >> 15;
                    state_reg <= S_M7;
                end
                S_M7:
                begin
                    if (b4_reg == 32'd0)
                    begin
                        err_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        b7_reg    <= prod;
                        state_reg <= S_M8;
                    end
                end
                S_M8:
                begin
                    hi_reg    <= b7_reg[31];
                    state_reg <= S_PDIV;
                end
                S_PDIV:
                begin
                    if (div_done)
                    begin
                        p_reg     <= hi_reg ? (div_q << 1) : div_q;
                        state_reg <= S_M9;
                    end
                end
                S_M9:
                begin
                    x1_reg    <= prod;
                    state_reg <= S_M10;
                end
                S_M10:
                begin
                    x1_reg    <= $unsigned($signed(prod) >>> 16);
                    state_reg <= S_M11;
                end
                S_M11:
                begin
                    x2_reg    <= $unsigned($signed(prod) >>> 16);
                    state_reg <= S_M12;
                end
                S_M12:
                begin
                    p_reg     <= p_reg + rnd;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_err_reg   <= err_reg;
                        out_temp_reg  <= err_reg ? 28'sd0 : $signed(b5p8[31:4]);
                        out_press_reg <= err_reg ? 32'sd0 : $signed(p_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.div_error |-> result.temp_tenths == 28'sd0
                                          && result.pressure_pa == 32'sd0)
        else $error("error result with nonzero fields");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside done state");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == S_T1)
        else $error("queue pop did not start an item");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_TDIV || state_reg == S_PDIV)
        else $error("divider finished outside a wait state");

endmodule

// File: hdl/barometric_compensation.sv
// Top level: configuration registers, front queue and compute back end.
//
//  channel  dir  payload
//  sample   in   raw_temp[15:0], raw_press[18:0]
//  result   out  temp_tenths[27:0] s, pressure_pa[31:0] s, div_error
//  cfg      in   reg_index[7:0], wdata[63:0]
//
// A sample without error waits twice on the shared bit-serial divider, and the
// sequencer steps around those waits share the single 32x32 multiplier.
// Error samples finish after the failing check.
// Reset clears queue, sequencer and result valid; calibration resets to zero,
// oversampling to 3. The two-entry queue takes samples while the back end
// works, and the result register lets the next sample start while one waits.
module barometric_compensation (
    input  logic        clk,
    input  logic        rst_n,
    bc_sample_if.sink   sample,
    bc_result_if.source result,
    bc_cfg_if.sink      cfg
);
    import bc_pkg::*;

    logic [63:0] cal_a_reg, cal_b_reg;
    logic [31:0] cal_c_reg;
    logic [1:0]  oss_reg;
    logic        pop;
    q_head_t     head;
    cal_t        cal;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= OSS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_CAL_A: cal_a_reg <= cfg.wdata;
                REG_CAL_B: cal_b_reg <= cfg.wdata;
                REG_CAL_C: cal_c_reg <= cfg.wdata[31:0];
                REG_OSS:   oss_reg   <= cfg.wdata[1:0];
                default: ;
            endcase
        end
    end

    assign cal = '{ac1: cal_a_reg[63:48], ac2: cal_a_reg[47:32],
                   ac3: cal_a_reg[31:16], ac4: cal_a_reg[15:0],
                   ac5: cal_b_reg[63:48], ac6: cal_b_reg[47:32],
                   b1:  cal_b_reg[31:16], b2:  cal_b_reg[15:0],
                   mc:  cal_c_reg[31:16], md:  cal_c_reg[15:0],
                   oss: oss_reg};

    bc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .pop    (pop),
        .head   (head)
    );

    bc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cal    (cal),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

// File: bench/tb_top.sv
// Testbench for barometric_compensation: predicts each sample's result and checks the output stream.
module tb_top;
    import bc_pkg::*;

    typedef struct {
        logic signed [27:0] temp_tenths;
        logic signed [31:0] pressure_pa;
        logic               div_error;
    } comp_res_t;

    class comp_scoreboard;
        comp_res_t pending[$];
        int        n_fail;
        int        n_checked;
        int        n_err;
        logic [63:0] cal_a;
        logic [63:0] cal_b;
        logic [31:0] cal_c;
        logic [1:0]  oss;

        function new();
            cal_a = 0;
            cal_b = 0;
            cal_c = 0;
            oss = OSS_RST;
        endfunction

        function void set_reg(reg_index_t idx, logic [63:0] v);
            case (idx)
                REG_CAL_A: cal_a = v;
                REG_CAL_B: cal_b = v;
                REG_CAL_C: cal_c = v[31:0];
                REG_OSS:   oss = v[1:0];
                default: ;
            endcase
        endfunction

        static function logic [31:0] ext16(logic [15:0] v);
            return {{16{v[15]}}, v};
        endfunction

        static function logic [31:0] sra(logic [31:0] x, int n);
            return $unsigned($signed(x) >>> n);
        endfunction

        static function logic [31:0] div_trunc(logic [31:0] n, logic [31:0] d);
            logic [31:0] an;
            logic [31:0] ad;
            logic [31:0] q;
            an = n[31] ? -n : n;
            ad = d[31] ? -d : d;
            q = an / ad;
            return (n[31] != d[31]) ? -q : q;
        endfunction

        function comp_res_t compensate(logic [15:0] ut_in, logic [18:0] up_in);
            comp_res_t r;
            logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
            logic [31:0] x1, x2, x3, dv, b5, t, b6, sq, b3, b4, b7, p;
            ac1 = ext16(cal_a[63:48]);
            ac2 = ext16(cal_a[47:32]);
            ac3 = ext16(cal_a[31:16]);
            ac4 = {16'd0, cal_a[15:0]};
            ac5 = {16'd0, cal_b[63:48]};
            ac6 = {16'd0, cal_b[47:32]};
            b1 = ext16(cal_b[31:16]);
            b2 = ext16(cal_b[15:0]);
            mc = ext16(cal_c[31:16]);
            md = ext16(cal_c[15:0]);
            r.temp_tenths = 0;
            r.pressure_pa = 0;
            r.div_error = 1;
            x1 = sra(({16'd0, ut_in} - ac6) * ac5, 15);
            dv = x1 + md;
            if (dv == 0)
                return r;
            x2 = div_trunc(mc << 11, dv);
            b5 = x1 + x2;
            t = sra(b5 + 8, 4);
            b6 = b5 - B6_OFS;
            sq = sra(b6 * b6, 12);
            x1 = sra(b2 * sq, 11);
            x2 = sra(ac2 * b6, 11);
            x3 = x1 + x2;
            b3 = div_trunc(((ac1 * 4 + x3) << oss) + 2, 4);
            x1 = sra(ac3 * b6, 13);
            x2 = sra(b1 * sq, 16);
            x3 = sra(x1 + x2 + 2, 2);
            b4 = (ac4 * (x3 + B4_OFS)) >> 15;
            if (b4 == 0)
                return r;
            b7 = ({13'd0, up_in} - b3) * (B7_NUM >> oss);
            if (b7 < SIGN_BIT)
                p = (b7 * 2) / b4;
            else
                p = (b7 / b4) * 2;
            x1 = sra(p, 8) * sra(p, 8);
            x1 = sra(x1 * P_K1, 16);
            x2 = sra(P_K2 * p, 16);
            p = p + sra(x1 + x2 + P_K3, 4);
            r.temp_tenths = t[27:0];
            r.pressure_pa = p;
            r.div_error = 0;
            return r;
        endfunction

        function void note_sample(logic [15:0] ut_in, logic [18:0] up_in);
            pending.push_back(compensate(ut_in, up_in));
        endfunction

        function void check_result(logic signed [27:0] tt, logic signed [31:0] pp, logic de);
            comp_res_t e;
            n_checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result t=%0d p=%0d err=%0b", $time, tt, pp, de);
                n_fail++;
                return;
            end
            e = pending.pop_front();
            if (de) n_err++;
            if (tt !== e.temp_tenths)
            begin
                $display("%0t: temp_tenths expected %0d actual %0d", $time, e.temp_tenths, tt);
                n_fail++;
            end
            if (pp !== e.pressure_pa)
            begin
                $display("%0t: pressure_pa expected %0d actual %0d", $time, e.pressure_pa, pp);
                n_fail++;
            end
            if (de !== e.div_error)
            begin
                $display("%0t: div_error expected %0b actual %0b", $time, e.div_error, de);
                n_fail++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    longint unsigned cycles = 0;
    localparam longint unsigned CYCLE_LIMIT = 1500000;

    bc_sample_if sample_ch();
    bc_result_if result_ch();
    bc_cfg_if    cfg_ch();

    barometric_compensation dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    comp_scoreboard sb = new();
    int n_sent = 0;
    bit quiet_sink = 0;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        sample_ch.valid = 0;
        sample_ch.raw_temp = 0;
        sample_ch.raw_press = 0;
        result_ch.ready = 0;
        cfg_ch.valid = 0;
        cfg_ch.reg_index = 0;
        cfg_ch.wdata = 0;
    end

    // result side: random stalls, sometimes none
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.temp_tenths, result_ch.pressure_pa, result_ch.div_error);
    end

    initial
    begin
        int w;
        @(posedge clk iff rst_n);
        forever
        begin
            w = quiet_sink ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w != 0)
            begin
                result_ch.ready <= 0;
                repeat (w) @(posedge clk);
            end
            result_ch.ready <= 1;
            @(posedge clk iff result_ch.valid);
        end
    end

    task automatic write_reg(reg_index_t idx, logic [63:0] v);
        cfg_ch.valid <= 1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata <= v;
        @(posedge clk iff cfg_ch.ready);
        cfg_ch.valid <= 0;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    // valid stays up after a request; a gap, drain or hold-off drops it
    task automatic send_sample(logic [15:0] ut_in, logic [18:0] up_in, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 17) : 0;
        if (w != 0)
        begin
            sample_ch.valid <= 0;
            repeat (w) @(posedge clk);
        end
        sample_ch.valid <= 1;
        sample_ch.raw_temp <= ut_in;
        sample_ch.raw_press <= up_in;
        @(posedge clk iff sample_ch.ready);
        sb.note_sample(ut_in, up_in);
        n_sent++;
    endtask

    task automatic drain();
        sample_ch.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // datasheet-like calibration randomized around nominal values, or random words when wild
    task automatic load_cal(bit wild, logic [1:0] o);
        logic [63:0] a, b;
        logic [31:0] c;
        if (wild)
        begin
            a = {$urandom, $urandom};
            b = {$urandom, $urandom};
            c = $urandom;
        end
        else
        begin
            a = {16'(408 + $urandom_range(0, 200)), 16'(-72 - $urandom_range(0, 40)),
                 16'(-14383 + $urandom_range(0, 300)), 16'(32741 - $urandom_range(0, 300))};
            b = {16'(32757 - $urandom_range(0, 300)), 16'(23153 + $urandom_range(0, 500)),
                 16'(6190 + $urandom_range(0, 100)), 16'(4 + $urandom_range(0, 4))};
            c = {16'(-8711 + $urandom_range(0, 200)), 16'(2868 + $urandom_range(0, 100))};
        end
        write_reg(REG_CAL_A, a);
        write_reg(REG_CAL_B, b);
        write_reg(REG_CAL_C, {32'd0, c});
        write_reg(REG_OSS, {62'd0, o});
    endtask

    initial
    begin
        int ph;
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset calibration is all zero: X1 + md == 0 gives a divide error
        send_sample(16'd27898, 19'd23843, 0);
        send_sample(16'hFFFF, 19'h7FFFF, 0);
        drain();

        // datasheet example values, all oversampling settings
        write_reg(REG_CAL_A, {16'd408, 16'(-72), 16'(-14383), 16'd32741});
        write_reg(REG_CAL_B, {16'd32757, 16'd23153, 16'd6190, 16'd4});
        write_reg(REG_CAL_C, {32'd0, 16'(-8711), 16'd2868});
        for (int o = 0; o < 4; o++)
        begin
            write_reg(REG_OSS, 64'(o));
            send_sample(16'd27898, 19'd23843, 0);
            send_sample(16'd0, 19'd0, 1);
            send_sample(16'hFFFF, 19'h7FFFF, 1);
            send_sample(16'h8000, 19'h40000, 0);
            drain();
        end
        // ac4 zero forces B4 zero
        write_reg(REG_CAL_A, {16'd408, 16'(-72), 16'(-14383), 16'd0});
        send_sample(16'd27898, 19'd23843, 0);
        drain();
        // md cancels X1: ac5 zero and md zero
        write_reg(REG_CAL_B, {16'd0, 16'd23153, 16'd6190, 16'd4});
        write_reg(REG_CAL_C, {32'd0, 16'h8000, 16'd0});
        send_sample(16'd1234, 19'd5, 0);
        drain();
        // extreme calibration words
        write_reg(REG_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_CAL_C, 64'h0000_0000_7FFF_8000);
        send_sample(16'hFFFF, 19'h7FFFF, 0);
        send_sample(16'h0000, 19'h00000, 0);
        drain();

        for (ph = 0; ph < 12; ph++)
        begin
            quiet_sink = (ph % 4 == 3);
            load_cal(ph % 3 == 2, 2'(ph % 4));
            for (k = 0; k < 90; k++)
            begin
                if ($urandom_range(0, 9) < 7)
                    send_sample(16'(25000 + $urandom_range(0, 10000)),
                                19'($urandom_range(0, 524287)), !quiet_sink);
                else
                    send_sample(16'($urandom), 19'($urandom), !quiet_sink);
                // hold off until the block has caught up
                if (k == 45)
                begin
                    sample_ch.valid <= 0;
                    @(posedge clk);
                    while (sb.pending.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        $display("Sent %0d samples over 12 calibration phases and all oversampling settings;",
                 n_sent);
        $display("%0d results checked, %0d with divide error.", sb.n_checked, sb.n_err);
        if (sb.n_fail == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: filelist.f
hdl/bc_pkg.sv
hdl/bc_if.sv
hdl/bc_front.sv
hdl/bc_div.sv
hdl/bc_core.sv
hdl/barometric_compensation.sv
bench/tb_top.sv
